// ===== design/pidet_pkg.sv =====
// shared types and constants for the pulse induction metal detector
`default_nettype none

package pidet_pkg;

    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 24;

    // configuration register indexes
    localparam logic [CFG_ADDR_W-1:0] CFG_PULSE_ON  = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_PULSE_OFF = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_WAIT_ZERO = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_WAIT_ONE  = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] CFG_MARGIN    = 3'd4;

    localparam logic [23:0] PULSE_ON_RST  = 24'd100;
    localparam logic [23:0] PULSE_OFF_RST = 24'd5000;
    localparam logic [15:0] WAIT_ZERO_RST = 16'd50;
    localparam logic [15:0] WAIT_ONE_RST  = 16'd200;
    localparam logic [15:0] MARGIN_RST    = 16'd2;

    typedef struct packed {
        logic [23:0] pulse_on_ticks;
        logic [23:0] pulse_off_ticks;
        logic [15:0] wait_zero_ticks;
        logic [15:0] wait_one_ticks;
        logic [15:0] detect_margin;
    } cfg_t;

    typedef struct packed {
        logic        gate_on;
        logic        calib_led;
        logic        detect_led;
        logic        average_valid;
        logic [15:0] average_value;
        logic        calib_failed;
    } result_t;

    typedef enum logic [4:0] {
        PH_IDLE  = 5'b00001,
        PH_ON    = 5'b00010,
        PH_WAIT0 = 5'b00100,
        PH_WAIT1 = 5'b01000,
        PH_OFF   = 5'b10000
    } phase_t;

endpackage

`default_nettype wire

// ===== design/pulse_induction_metal_detector_top.sv =====
// Pulse induction metal detector controller. Each input transaction is one
// timer tick carrying the back EMF comparator level and the calibrate and
// detect requests; each tick yields exactly one result transaction with the
// gate drive, both LEDs and, at the end of a run, the averaged decay count.
// One tick is taken per clock cycle unless the output stalls: the sequencer
// state advances in a single pass from the state registers to the result
// register, and the average is a single reciprocal multiply of the count sum.
// A new tick is accepted while the result register is empty or its result is
// being taken in the same cycle, so a result appears in the cycle after its tick.
// AVG_COUNT (1 to 255) sets the pulses per run. Configuration writes are taken at once.
`default_nettype none

module pulse_induction_metal_detector_top #(
    parameter int AVG_COUNT = 25
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,

    input  wire logic                               cfg_we,
    input  wire logic [pidet_pkg::CFG_ADDR_W-1:0]   cfg_addr,
    input  wire logic [pidet_pkg::CFG_DATA_W-1:0]   cfg_wdata,

    input  wire logic                               s_valid,
    output logic                                    s_ready,
    input  wire logic                               s_bemf_level,
    input  wire logic                               s_calib_request,
    input  wire logic                               s_detect_request,

    output logic                                    m_valid,
    input  wire logic                               m_ready,
    output logic                                    m_gate_on,
    output logic                                    m_calib_led,
    output logic                                    m_detect_led,
    output logic                                    m_average_valid,
    output logic [15:0]                             m_average_value,
    output logic                                    m_calib_failed
);

    pidet_pkg::cfg_t    cfg;
    pidet_pkg::result_t result;
    pidet_pkg::result_t result_reg;
    logic               m_valid_reg;
    logic               accept;

    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;

    pidet_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    pidet_ctrl #(
        .AVG_COUNT (AVG_COUNT)
    ) u_ctrl (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .advance        (accept),
        .bemf_level     (s_bemf_level),
        .calib_request  (s_calib_request),
        .detect_request (s_detect_request),
        .cfg            (cfg),
        .result         (result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= accept || (m_valid_reg && !m_ready);
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            result_reg <= result;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_gate_on       = result_reg.gate_on;
    assign m_calib_led     = result_reg.calib_led;
    assign m_detect_led    = result_reg.detect_led;
    assign m_average_valid = result_reg.average_valid;
    assign m_average_value = result_reg.average_value;
    assign m_calib_failed  = result_reg.calib_failed;

    // every accepted tick leaves a result transaction behind
    a_tick_gives_result: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> m_valid)
        else $error("accepted tick produced no result");

    // a failure flag only comes with a finished run
    a_failed_needs_avg: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_calib_failed |-> m_average_valid)
        else $error("calib_failed outside a finished run");

    // the average is zero outside the finishing tick
    a_avg_zero_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_average_valid |-> m_average_value == 16'd0)
        else $error("average_value set without average_valid");

    // the gate is never driven in the tick a run finishes
    a_gate_off_at_end: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_average_valid |-> !m_gate_on)
        else $error("gate on while run finishes");

endmodule

`default_nettype wire

// ===== design/pidet_cfg.sv =====
// configuration register file
`default_nettype none

module pidet_cfg (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                cfg_we,
    input  wire logic [pidet_pkg::CFG_ADDR_W-1:0]    cfg_addr,
    input  wire logic [pidet_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    output pidet_pkg::cfg_t                          cfg
);

    pidet_pkg::cfg_t cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.pulse_on_ticks  <= pidet_pkg::PULSE_ON_RST;
            cfg_reg.pulse_off_ticks <= pidet_pkg::PULSE_OFF_RST;
            cfg_reg.wait_zero_ticks <= pidet_pkg::WAIT_ZERO_RST;
            cfg_reg.wait_one_ticks  <= pidet_pkg::WAIT_ONE_RST;
            cfg_reg.detect_margin   <= pidet_pkg::MARGIN_RST;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                pidet_pkg::CFG_PULSE_ON:  cfg_reg.pulse_on_ticks  <= cfg_wdata;
                pidet_pkg::CFG_PULSE_OFF: cfg_reg.pulse_off_ticks <= cfg_wdata;
                pidet_pkg::CFG_WAIT_ZERO: cfg_reg.wait_zero_ticks <= cfg_wdata[15:0];
                pidet_pkg::CFG_WAIT_ONE:  cfg_reg.wait_one_ticks  <= cfg_wdata[15:0];
                pidet_pkg::CFG_MARGIN:    cfg_reg.detect_margin   <= cfg_wdata[15:0];
                default: ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

// ===== design/pidet_div.sv =====
// divide the decay count sum by the pulse count using a reciprocal multiply
`default_nettype none

module pidet_div #(
    parameter int AVG_COUNT = 25,
    parameter int SUM_W     = 21
) (
    input  wire logic [SUM_W-1:0] count_sum,
    output logic      [15:0]      average
);

    // ceil(2^SHIFT / AVG_COUNT) is exact for every SUM_W-bit dividend
    localparam int          SHIFT   = SUM_W + $clog2(AVG_COUNT);
    localparam int          RECIP_W = SUM_W + 2;
    localparam logic [63:0] RECIP64 =
        ((64'd1 << SHIFT) + 64'(AVG_COUNT) - 64'd1) / 64'(AVG_COUNT);
    localparam logic [RECIP_W-1:0] RECIP = RECIP64[RECIP_W-1:0];

    logic [SUM_W+RECIP_W-1:0] product;

    assign product = (SUM_W+RECIP_W)'(count_sum) * (SUM_W+RECIP_W)'(RECIP);
    assign average = product[SHIFT +: 16];

endmodule

`default_nettype wire

// ===== design/pidet_ctrl.sv =====
// pulse sequencer, edge timing, accumulation and led state
`default_nettype none

module pidet_ctrl #(
    parameter int AVG_COUNT = 25
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             advance,
    input  wire logic             bemf_level,
    input  wire logic             calib_request,
    input  wire logic             detect_request,
    input  wire pidet_pkg::cfg_t  cfg,
    output pidet_pkg::result_t    result
);

    localparam int PIDX_W = $clog2(AVG_COUNT + 1);
    localparam int SUM_W  = $clog2(AVG_COUNT * 65536);
    localparam logic [PIDX_W-1:0] LAST_PULSE = PIDX_W'(AVG_COUNT);

    pidet_pkg::phase_t  phase_reg, phase_next;
    logic [23:0]        tick_count_reg, tick_count_next;
    logic [PIDX_W-1:0]  pulse_index_reg, pulse_index_next;
    logic [SUM_W-1:0]   count_sum_reg, count_sum_next;
    logic               timeout_seen_reg, timeout_seen_next;
    logic               run_is_cal_reg, run_is_cal_next;
    logic [15:0]        cal_value_reg, cal_value_next;
    logic               calib_led_reg, calib_led_next;
    logic               detect_led_reg, detect_led_next;
    logic               prev_bemf_reg;

    logic               rise, fall;
    logic [23:0]        tick_inc;
    logic [PIDX_W-1:0]  pulse_inc;
    logic [15:0]        capture;
    logic [15:0]        average;
    logic [16:0]        threshold;

    pidet_div #(
        .AVG_COUNT (AVG_COUNT),
        .SUM_W     (SUM_W)
    ) u_div (
        .count_sum (count_sum_reg),
        .average   (average)
    );

    assign rise      = !prev_bemf_reg && bemf_level;
    assign fall      = prev_bemf_reg && !bemf_level;
    assign tick_inc  = tick_count_reg + 24'd1;
    assign pulse_inc = pulse_index_reg + PIDX_W'(1);
    assign capture   = rise ? tick_count_reg[15:0] : cfg.wait_one_ticks;
    assign threshold = {1'b0, cal_value_reg} + {1'b0, cfg.detect_margin};

    always_comb begin
        phase_next        = phase_reg;
        tick_count_next   = tick_count_reg;
        pulse_index_next  = pulse_index_reg;
        count_sum_next    = count_sum_reg;
        timeout_seen_next = timeout_seen_reg;
        run_is_cal_next   = run_is_cal_reg;
        cal_value_next    = cal_value_reg;
        calib_led_next    = calib_led_reg;
        detect_led_next   = detect_led_reg;
        result            = '0;

        unique case (phase_reg)
            pidet_pkg::PH_ON: begin
                result.gate_on = 1'b1;
                if (tick_inc >= cfg.pulse_on_ticks) begin
                    phase_next      = pidet_pkg::PH_WAIT0;
                    tick_count_next = '0;
                end else begin
                    tick_count_next = tick_inc;
                end
            end
            pidet_pkg::PH_WAIT0: begin
                // the falling edge only releases the wait, its time is dropped
                if (fall || tick_count_reg >= {8'd0, cfg.wait_zero_ticks}) begin
                    phase_next      = pidet_pkg::PH_WAIT1;
                    tick_count_next = '0;
                end else begin
                    tick_count_next = tick_inc;
                end
            end
            pidet_pkg::PH_WAIT1: begin
                if (rise || tick_count_reg >= {8'd0, cfg.wait_one_ticks}) begin
                    count_sum_next = count_sum_reg + SUM_W'(capture);
                    if (capture == cfg.wait_one_ticks) begin
                        timeout_seen_next = 1'b1;
                    end
                    phase_next      = pidet_pkg::PH_OFF;
                    tick_count_next = '0;
                end else begin
                    tick_count_next = tick_inc;
                end
            end
            pidet_pkg::PH_OFF: begin
                if (tick_inc >= cfg.pulse_off_ticks) begin
                    tick_count_next  = '0;
                    pulse_index_next = pulse_inc;
                    if (pulse_inc >= LAST_PULSE) begin
                        result.average_valid = 1'b1;
                        result.average_value = average;
                        result.calib_failed  = timeout_seen_reg;
                        if (run_is_cal_reg) begin
                            if (timeout_seen_reg) begin
                                calib_led_next = 1'b1;
                            end else begin
                                calib_led_next = 1'b0;
                                cal_value_next = average;
                            end
                        end else begin
                            detect_led_next = ({1'b0, average} > threshold);
                        end
                        phase_next = pidet_pkg::PH_IDLE;
                    end else begin
                        phase_next = pidet_pkg::PH_ON;
                    end
                end else begin
                    tick_count_next = tick_inc;
                end
            end
            default: begin
                // idle, and any stray code falls back to idle
                phase_next = pidet_pkg::PH_IDLE;
                if (!detect_request) begin
                    detect_led_next = 1'b0;
                end
                if (calib_request || (cal_value_reg != 16'd0 && detect_request)) begin
                    run_is_cal_next   = calib_request;
                    phase_next        = pidet_pkg::PH_ON;
                    tick_count_next   = '0;
                    pulse_index_next  = '0;
                    count_sum_next    = '0;
                    timeout_seen_next = 1'b0;
                end
            end
        endcase

        result.calib_led  = calib_led_next;
        result.detect_led = detect_led_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg        <= pidet_pkg::PH_IDLE;
            tick_count_reg   <= '0;
            pulse_index_reg  <= '0;
            count_sum_reg    <= '0;
            timeout_seen_reg <= 1'b0;
            run_is_cal_reg   <= 1'b0;
            cal_value_reg    <= '0;
            calib_led_reg    <= 1'b1;
            detect_led_reg   <= 1'b0;
            prev_bemf_reg    <= 1'b1;
        end else if (advance) begin
            phase_reg        <= phase_next;
            tick_count_reg   <= tick_count_next;
            pulse_index_reg  <= pulse_index_next;
            count_sum_reg    <= count_sum_next;
            timeout_seen_reg <= timeout_seen_next;
            run_is_cal_reg   <= run_is_cal_next;
            cal_value_reg    <= cal_value_next;
            calib_led_reg    <= calib_led_next;
            detect_led_reg   <= detect_led_next;
            prev_bemf_reg    <= bemf_level;
        end
    end

endmodule

`default_nettype wire
